@@ rtl/vbffa_pkg.sv @@
// Shared types, codes and helpers of the VRAM bank first-fit allocator.
`default_nettype none

package vbffa_pkg;

	localparam logic [1:0] KIND_INIT   = 2'd0;
	localparam logic [1:0] KIND_CREATE = 2'd1;
	localparam logic [1:0] KIND_DELETE = 2'd2;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_LAYER   = 3'd1;
	localparam logic [2:0] ST_BAD_SIZE    = 3'd2;
	localparam logic [2:0] ST_NO_TILE     = 3'd3;
	localparam logic [2:0] ST_NO_MAP      = 3'd4;
	localparam logic [2:0] ST_NOT_CREATED = 3'd5;

	localparam int unsigned LAYERS         = 4;
	localparam int unsigned NEED_W         = 6;
	localparam int unsigned TILE_BANK_LOG2 = 14;
	localparam int unsigned MAP_BANK_LOG2  = 11;
	localparam logic [15:0] MAX_TILE_BYTES = 16'd16384;
	localparam logic [9:0]  BG_SMALL       = 10'd256;
	localparam logic [9:0]  BG_LARGE       = 10'd512;

	typedef struct packed {
		logic [1:0]  kind;
		logic        screen;
		logic [1:0]  layer;
		logic [15:0] tile_bytes;
		logic [15:0] map_bytes;
		logic [9:0]  bg_width;
		logic [9:0]  bg_height;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] tile_base;
		logic [3:0] tile_count;
		logic [3:0] map_base;
		logic [4:0] map_count;
	} rsp_t;

	typedef struct packed {
		logic done;
		logic found;
	} scan_st_t;

	// ceil(bytes / bank size), zero bytes still takes one bank
	function automatic logic [NEED_W-1:0] banks_needed(input logic [15:0] bytes,
		input int unsigned log2size);
		logic [15:0] t;
		t = (bytes - 16'd1) >> log2size;
		if (bytes == 16'd0) begin
			return NEED_W'(1);
		end
		return NEED_W'(t) + NEED_W'(1);
	endfunction

endpackage

`default_nettype wire

@@ rtl/vbffa_scan.sv @@
// First-fit run finder: walks one bank a cycle looking for a free run.
`default_nettype none

module vbffa_scan #(
	parameter int unsigned N = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              go,
	input  logic [N-1:0]                      busy,
	input  logic [$clog2(N+1)-1:0]            len,
	input  logic [vbffa_pkg::NEED_W-1:0]      need,
	output vbffa_pkg::scan_st_t               st,
	output logic [$clog2(N)-1:0]              base
);
	import vbffa_pkg::*;

	localparam int unsigned IW = $clog2(N);
	localparam int unsigned LW = $clog2(N + 1);

	logic              active_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     start_q;
	logic [NEED_W-1:0] run_q;
	logic [NEED_W:0]   run_nx;
	logic              free_b;
	logic              hit;
	logic              last;

	always_comb begin
		free_b   = !busy[idx_q];
		run_nx   = free_b ? ({1'b0, run_q} + (NEED_W+1)'(1)) : '0;
		hit      = free_b && (run_nx >= {1'b0, need});
		last     = ((LW'(idx_q) + LW'(1)) == len);
		base     = (run_q == '0) ? idx_q : start_q;
		st.done  = active_q && (hit || last);
		st.found = active_q && hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			start_q  <= '0;
			run_q    <= '0;
		end else if (go) begin
			active_q <= 1'b1;
			idx_q    <= '0;
			start_q  <= '0;
			run_q    <= '0;
		end else if (active_q) begin
			if (st.done) begin
				active_q <= 1'b0;
			end
			if (free_b && run_q == '0) begin
				start_q <= idx_q;
			end
			run_q <= NEED_W'(run_nx);
			idx_q <= idx_q + IW'(1);
		end
	end

endmodule

`default_nettype wire

@@ rtl/vram_bank_first_fit_allocator.sv @@
// Top level of the VRAM bank first-fit allocator: sequencer, pools and layer records.
//
// One item is taken at a time. Init, delete, unknown kinds and rejected creates
// pass from the execute state straight to the done state; a create that reaches
// the search walks the tile pool and, once a tile run is found, the map pool one
// bank per cycle through a single shared first-fit scanner before it reaches the
// done state. The next item can be taken as soon as the result has been loaded
// into the output register, even while that result is still stalled. Reset
// leaves every screen freshly initialised: the lowest ceil(MAP_BANKS/8) tile
// banks (at most TILE_BANKS) are held for maps, all map banks are free and no
// layer is created.
`default_nettype none

module vram_bank_first_fit_allocator #(
	parameter int unsigned TILE_BANKS = 8,
	parameter int unsigned MAP_BANKS  = 16,
	parameter int unsigned SCREENS    = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  vbffa_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output vbffa_pkg::rsp_t rsp
);
	import vbffa_pkg::*;

	localparam int unsigned RES_RAW = ((MAP_BANKS - 1) >> 3) + 1;
	localparam int unsigned RESERVE = (RES_RAW > TILE_BANKS) ? TILE_BANKS : RES_RAW;
	localparam int unsigned SCAN_N  = (TILE_BANKS > MAP_BANKS) ? TILE_BANKS : MAP_BANKS;
	localparam int unsigned SCAN_IW = $clog2(SCAN_N);
	localparam int unsigned SCAN_LW = $clog2(SCAN_N + 1);
	localparam int unsigned SIW     = (SCREENS > 1) ? $clog2(SCREENS) : 1;
	localparam int unsigned TBW     = $clog2(TILE_BANKS);
	localparam int unsigned TCW     = $clog2(TILE_BANKS + 1);
	localparam int unsigned MBW     = $clog2(MAP_BANKS);
	localparam int unsigned MCW     = $clog2(MAP_BANKS + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_TSCAN = 5'b00100,
		S_MSCAN = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	function automatic logic [TILE_BANKS-1:0] tile_range(input int unsigned b,
		input int unsigned c);
		logic [TILE_BANKS-1:0] m;
		for (int unsigned i = 0; i < TILE_BANKS; i++) begin
			m[i] = (i >= b) && (i < b + c);
		end
		return m;
	endfunction

	function automatic logic [MAP_BANKS-1:0] map_range(input int unsigned b,
		input int unsigned c);
		logic [MAP_BANKS-1:0] m;
		for (int unsigned i = 0; i < MAP_BANKS; i++) begin
			m[i] = (i >= b) && (i < b + c);
		end
		return m;
	endfunction

	function automatic logic [TILE_BANKS-1:0] reserve_mask();
		logic [TILE_BANKS-1:0] m;
		for (int unsigned i = 0; i < TILE_BANKS; i++) begin
			m[i] = (i < RESERVE);
		end
		return m;
	endfunction

	function automatic rsp_t answer_of(input logic [2:0] status_v,
		input logic [3:0] tc, input logic [4:0] mc);
		rsp_t r;
		r            = '0;
		r.status     = status_v;
		r.tile_count = tc;
		r.map_count  = mc;
		return r;
	endfunction

	state_t state_q;
	req_t   req_q;
	rsp_t   res_q;
	rsp_t   rsp_q;
	logic   rsp_valid_q;

	logic [TILE_BANKS-1:0] tile_busy_q [SCREENS];
	logic [MAP_BANKS-1:0]  map_busy_q  [SCREENS];
	logic                  created_q   [SCREENS][LAYERS];
	logic [TBW-1:0]        rec_tb_q    [SCREENS][LAYERS];
	logic [TCW-1:0]        rec_tc_q    [SCREENS][LAYERS];
	logic [MBW-1:0]        rec_mb_q    [SCREENS][LAYERS];
	logic [MCW-1:0]        rec_mc_q    [SCREENS][LAYERS];
	logic [TBW-1:0]        tstart_q;

	logic                  scr_ok;
	logic [SIW-1:0]        sidx;
	logic [1:0]            lidx;
	logic                  layer_ok;
	logic                  size_ok;
	logic                  exec_scan;
	logic [NEED_W-1:0]     tneed;
	logic [NEED_W-1:0]     mneed;
	logic [TILE_BANKS-1:0] tfree_mask;
	logic [MAP_BANKS-1:0]  mfree_mask;
	logic [TILE_BANKS-1:0] tmark_mask;
	logic [MAP_BANKS-1:0]  mmark_mask;

	logic                  scan_go;
	logic [SCAN_N-1:0]     scan_vec;
	logic [SCAN_LW-1:0]    scan_len;
	logic [NEED_W-1:0]     scan_need;
	scan_st_t              scan_st;
	logic [SCAN_IW-1:0]    scan_base;

	always_comb begin
		scr_ok    = (32'(req_q.screen) < SCREENS);
		sidx      = scr_ok ? SIW'(req_q.screen) : '0;
		lidx      = req_q.layer;
		layer_ok  = (req_q.layer == 2'd2) || (req_q.layer == 2'd3);
		size_ok   = ((req_q.bg_width == BG_SMALL && req_q.bg_height == BG_SMALL) ||
		             (req_q.bg_width == BG_LARGE && req_q.bg_height == BG_LARGE)) &&
		            (req_q.tile_bytes <= MAX_TILE_BYTES);
		tneed     = banks_needed(req_q.tile_bytes, TILE_BANK_LOG2);
		mneed     = banks_needed(req_q.map_bytes, MAP_BANK_LOG2);
		exec_scan = (state_q == S_EXEC) && scr_ok && (req_q.kind == KIND_CREATE) &&
		            layer_ok && size_ok;
		tfree_mask = tile_range(32'(rec_tb_q[sidx][lidx]), 32'(rec_tc_q[sidx][lidx]));
		mfree_mask = map_range(32'(rec_mb_q[sidx][lidx]), 32'(rec_mc_q[sidx][lidx]));
		tmark_mask = tile_range(32'(tstart_q), 32'(tneed));
		mmark_mask = map_range(32'(scan_base), 32'(mneed));
		scan_go   = exec_scan ||
		            ((state_q == S_TSCAN) && scan_st.done && scan_st.found);
		if (state_q == S_TSCAN) begin
			scan_vec  = SCAN_N'(tile_busy_q[sidx]);
			scan_len  = SCAN_LW'(TILE_BANKS);
			scan_need = tneed;
		end else begin
			scan_vec  = SCAN_N'(map_busy_q[sidx]);
			scan_len  = SCAN_LW'(MAP_BANKS);
			scan_need = mneed;
		end
	end

	vbffa_scan #(
		.N(SCAN_N)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (scan_go),
		.busy   (scan_vec),
		.len    (scan_len),
		.need   (scan_need),
		.st     (scan_st),
		.base   (scan_base)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			tstart_q    <= '0;
			for (int s = 0; s < SCREENS; s++) begin
				tile_busy_q[s] <= reserve_mask();
				map_busy_q[s]  <= '0;
				for (int l = 0; l < LAYERS; l++) begin
					created_q[s][l] <= 1'b0;
					rec_tb_q[s][l]  <= '0;
					rec_tc_q[s][l]  <= '0;
					rec_mb_q[s][l]  <= '0;
					rec_mc_q[s][l]  <= '0;
				end
			end
		end else begin
			if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= exec_scan ? S_TSCAN : S_DONE;
					if (!scr_ok) begin
						res_q <= answer_of(ST_BAD_LAYER, '0, '0);
					end else begin
						unique case (req_q.kind)
							KIND_INIT: begin
								res_q <= answer_of(ST_OK, '0, '0);
								tile_busy_q[sidx] <= reserve_mask();
								map_busy_q[sidx]  <= '0;
								for (int l = 0; l < LAYERS; l++) begin
									created_q[sidx][l] <= 1'b0;
									rec_tb_q[sidx][l]  <= '0;
									rec_tc_q[sidx][l]  <= '0;
									rec_mb_q[sidx][l]  <= '0;
									rec_mc_q[sidx][l]  <= '0;
								end
							end
							KIND_CREATE: begin
								if (!layer_ok) begin
									res_q <= answer_of(ST_BAD_LAYER, '0, '0);
								end else begin
									if (created_q[sidx][lidx]) begin
										tile_busy_q[sidx] <= tile_busy_q[sidx] & ~tfree_mask;
										map_busy_q[sidx]  <= map_busy_q[sidx] & ~mfree_mask;
										created_q[sidx][lidx] <= 1'b0;
										rec_tb_q[sidx][lidx]  <= '0;
										rec_tc_q[sidx][lidx]  <= '0;
										rec_mb_q[sidx][lidx]  <= '0;
										rec_mc_q[sidx][lidx]  <= '0;
									end
									if (!size_ok) begin
										res_q <= answer_of(ST_BAD_SIZE, '0, '0);
									end else begin
										res_q <= answer_of(ST_OK, '0, '0);
									end
								end
							end
							KIND_DELETE: begin
								if (!created_q[sidx][lidx]) begin
									res_q <= answer_of(ST_NOT_CREATED, '0, '0);
								end else begin
									res_q <= answer_of(ST_OK, 4'(rec_tc_q[sidx][lidx]),
										5'(rec_mc_q[sidx][lidx]));
									tile_busy_q[sidx] <= tile_busy_q[sidx] & ~tfree_mask;
									map_busy_q[sidx]  <= map_busy_q[sidx] & ~mfree_mask;
									created_q[sidx][lidx] <= 1'b0;
									rec_tb_q[sidx][lidx]  <= '0;
									rec_tc_q[sidx][lidx]  <= '0;
									rec_mb_q[sidx][lidx]  <= '0;
									rec_mc_q[sidx][lidx]  <= '0;
								end
							end
							default: begin
								res_q <= answer_of(ST_OK, '0, '0);
							end
						endcase
					end
				end
				S_TSCAN: begin
					if (scan_st.done) begin
						if (!scan_st.found) begin
							res_q.status <= ST_NO_TILE;
							state_q      <= S_DONE;
						end else begin
							tstart_q <= TBW'(scan_base);
							state_q  <= S_MSCAN;
						end
					end
				end
				S_MSCAN: begin
					if (scan_st.done) begin
						state_q <= S_DONE;
						if (!scan_st.found) begin
							res_q.status <= ST_NO_MAP;
						end else begin
							tile_busy_q[sidx]     <= tile_busy_q[sidx] | tmark_mask;
							map_busy_q[sidx]      <= map_busy_q[sidx] | mmark_mask;
							created_q[sidx][lidx] <= 1'b1;
							rec_tb_q[sidx][lidx]  <= tstart_q;
							rec_tc_q[sidx][lidx]  <= TCW'(tneed);
							rec_mb_q[sidx][lidx]  <= MBW'(scan_base);
							rec_mc_q[sidx][lidx]  <= MCW'(mneed);
							res_q.tile_base  <= 3'(tstart_q);
							res_q.tile_count <= 4'(tneed);
							res_q.map_base   <= 4'(scan_base);
							res_q.map_count  <= 5'(mneed);
						end
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_q.status != ST_OK) |->
		(res_q.tile_count == '0 && res_q.map_count == '0 &&
		 res_q.tile_base == '0 && res_q.map_base == '0))
		else $error("failed item carries a non-zero allocation");

	a_run_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_st.done && scan_st.found) |->
		(32'(scan_base) + 32'(scan_need) <= 32'(scan_len)))
		else $error("first-fit run runs past the end of the pool");

	a_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		tile_busy_q[0][0])
		else $error("tile bank held for maps has been released");
`endif

endmodule

`default_nettype wire
